### hw/rtl/sprg_pkg.sv
// Shared types and codes for the stepper pulse ramp generator
package sprg_pkg;

   localparam int unsigned FREQ_W  = 16;
   localparam int unsigned COUNT_W = 32;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic               direction;
      logic [FREQ_W-1:0]  start_freq;
      logic [FREQ_W-1:0]  accel_step;
      logic [FREQ_W-1:0]  accel_pulses;
      logic [FREQ_W-1:0]  decel_step;
      logic [FREQ_W-1:0]  decel_pulses;
      logic [COUNT_W-1:0] pulse_total;
   } req_payload_type;

   typedef struct packed {
      logic               pulse_level;
      logic               direction_level;
      logic [FREQ_W-1:0]  step_freq;
      logic               freq_changed;
      logic [COUNT_W-1:0] pulses_done;
      logic               running;
      logic               finished;
      logic               tick_handled;
   } rsp_payload_type;

endpackage

### hw/rtl/sprg_if.sv
// Valid/ready channel interfaces for requests and responses
interface sprg_req_if;
   logic                     valid;
   logic                     ready;
   sprg_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sprg_rsp_if;
   logic                     valid;
   logic                     ready;
   sprg_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/stepper_pulse_ramp_generator.sv
// Stepper pulse sequencer with a linear speed ramp, one response per request
// The response is registered: it appears in the cycle after the request transaction.
// Throughput: one transaction per cycle while responses are taken; the move state
// updates at acceptance and the response slot frees when the consumer takes it.
// Reset (synchronous, active high) clears the move state, direction line and
// the response valid flag.
module stepper_pulse_ramp_generator (
   input  logic              clock,
   input  logic              reset,
   sprg_req_if.sink          req_channel,
   sprg_rsp_if.source        rsp_channel
);

   localparam int unsigned FW = sprg_pkg::FREQ_W;
   localparam int unsigned CW = sprg_pkg::COUNT_W;

   // move state
   logic          run_ff, run_in;
   logic          pulse_ff, pulse_in;
   logic          dir_ff, dir_in;
   logic [FW-1:0] freq_ff, freq_in;
   logic [FW-1:0] up_step_ff, up_step_in;
   logic [FW-1:0] up_count_ff, up_count_in;
   logic [FW-1:0] down_step_ff, down_step_in;
   logic [FW-1:0] down_count_ff, down_count_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] done_ff, done_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   sprg_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic changed, finished, handled;

   // ramp helpers
   logic [FW:0]   freq_up_sum;
   logic [FW-1:0] freq_up_sat;
   logic [FW-1:0] freq_down_sat;
   logic [CW:0]   decel_reach;
   logic          in_accel;
   logic          in_decel;

   sprg_pkg::req_payload_type req;

   assign req    = req_channel.payload;
   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;

   // saturating ramp arithmetic and phase windows
   always_comb begin
      freq_up_sum   = {1'b0, freq_ff} + {1'b0, up_step_ff};
      freq_up_sat   = freq_up_sum[FW] ? sprg_pkg::FREQ_MAX : freq_up_sum[FW-1:0];
      freq_down_sat = (freq_ff > down_step_ff) ? (freq_ff - down_step_ff) : '0;
      decel_reach   = {1'b0, done_ff} + {{(CW-FW+1){1'b0}}, down_count_ff};
      in_accel      = (up_step_ff != '0) && (up_count_ff != '0)
                      && (done_ff < {{(CW-FW){1'b0}}, up_count_ff});
      in_decel      = (down_step_ff != '0) && (down_count_ff != '0)
                      && (decel_reach > {1'b0, total_ff});
   end

   // next move state for the accepted request
   always_comb begin
      run_in        = run_ff;
      pulse_in      = pulse_ff;
      dir_in        = dir_ff;
      freq_in       = freq_ff;
      up_step_in    = up_step_ff;
      up_count_in   = up_count_ff;
      down_step_in  = down_step_ff;
      down_count_in = down_count_ff;
      total_in      = total_ff;
      done_in       = done_ff;
      changed       = 1'b0;
      finished      = 1'b0;
      handled       = 1'b0;
      if (accept) begin
         unique case (req.operation)
            sprg_pkg::OP_TICK: begin
               if (run_ff) begin
                  handled = 1'b1;
                  if (done_ff >= total_ff) begin
                     // move complete: halt the timer, hold the line low
                     run_in   = 1'b0;
                     pulse_in = 1'b0;
                     finished = 1'b1;
                  end else if (pulse_ff) begin
                     // falling edge: count one pulse
                     pulse_in = 1'b0;
                     done_in  = done_ff + CW'(1);
                  end else begin
                     // rising edge: take a ramp step
                     pulse_in = 1'b1;
                     if (in_accel) begin
                        freq_in = freq_up_sat;
                        changed = 1'b1;
                     end else if (in_decel) begin
                        freq_in = freq_down_sat;
                        changed = 1'b1;
                     end
                  end
               end
            end
            sprg_pkg::OP_START: begin
               pulse_in = 1'b0;
               if ((req.start_freq != '0) && (req.pulse_total != '0)) begin
                  dir_in        = req.direction;
                  freq_in       = req.start_freq;
                  up_step_in    = req.accel_step;
                  up_count_in   = req.accel_pulses;
                  down_step_in  = req.decel_step;
                  down_count_in = req.decel_pulses;
                  total_in      = req.pulse_total;
                  done_in       = '0;
                  run_in        = 1'b1;
                  changed       = 1'b1;
               end
            end
            sprg_pkg::OP_STOP: begin
               // clear the move, keep the direction line
               run_in        = 1'b0;
               pulse_in      = 1'b0;
               freq_in       = '0;
               up_step_in    = '0;
               up_count_in   = '0;
               down_step_in  = '0;
               down_count_in = '0;
               total_in      = '0;
               done_in       = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // response slot: load on acceptance, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.pulse_level     = pulse_in;
         rsp_data_in.direction_level = dir_in;
         rsp_data_in.step_freq       = freq_in;
         rsp_data_in.freq_changed    = changed;
         rsp_data_in.pulses_done     = done_in;
         rsp_data_in.running         = run_in;
         rsp_data_in.finished        = finished;
         rsp_data_in.tick_handled    = handled;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and move state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         pulse_ff      <= 1'b0;
         dir_ff        <= 1'b0;
         freq_ff       <= '0;
         up_step_ff    <= '0;
         up_count_ff   <= '0;
         down_step_ff  <= '0;
         down_count_ff <= '0;
         total_ff      <= '0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_ff        <= run_in;
         pulse_ff      <= pulse_in;
         dir_ff        <= dir_in;
         freq_ff       <= freq_in;
         up_step_ff    <= up_step_in;
         up_count_ff   <= up_count_in;
         down_step_ff  <= down_step_in;
         down_count_ff <= down_count_in;
         total_ff      <= total_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_data_ff;

endmodule
